@@ rtl/nfwlz_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfwlz_pkg
// shared types and constants of the near/far word lz expander
// ----------------------------------------------------------------------------
package nfwlz_pkg;

    // reset values of the command tags
    localparam logic [7:0] NEAR_TAG_RST = 8'hA7;
    localparam logic [7:0] FAR_TAG_RST  = 8'hA8;

    // decode outcome of one item
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_LIT  = 2'd1;
    localparam logic [1:0] ACT_COPY = 2'd2;
    localparam logic [1:0] ACT_BAD  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic rd;
        logic wr;
        logic emit;
        logic emit_err;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] act;
        logic       fill;
        logic       last_word;
        logic       cnt_zero;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/nfwlz_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfwlz_in_if
// compressed byte channel
// ----------------------------------------------------------------------------
interface nfwlz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface
`default_nettype wire

@@ rtl/nfwlz_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfwlz_out_if
// expanded word result channel
// ----------------------------------------------------------------------------
interface nfwlz_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [2:0]  word_count;
    logic        last_of_run;
    logic        bad_pointer;

    modport source (output valid, output word_a, output word_b, output word_c,
                    output word_d, output word_count, output last_of_run,
                    output bad_pointer, input ready);
    modport sink   (input valid, input word_a, input word_b, input word_c,
                    input word_d, input word_count, input last_of_run,
                    input bad_pointer, output ready);
endinterface
`default_nettype wire

@@ rtl/nfwlz_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfwlz_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module nfwlz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/nfwlz_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfwlz_datapath
// byte parser, history store, copy pointers, word packing, result register
// ----------------------------------------------------------------------------
module nfwlz_datapath
    import nfwlz_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 4096,
    parameter int WORDS_PER_RESULT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output      t_sts        o_sts,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_stream_start,
    input  wire logic [7:0]  i_near_tag,
    input  wire logic [7:0]  i_far_tag,
    nfwlz_out_if.source      o_out
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int WPR = WORDS_PER_RESULT;
    localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);
    localparam logic [15:0] WP_MAX = 16'hFFFF;

    localparam logic [2:0] PH_HDR_LO   = 3'd0;
    localparam logic [2:0] PH_HDR_HI   = 3'd1;
    localparam logic [2:0] PH_W_LO     = 3'd2;
    localparam logic [2:0] PH_W_HI     = 3'd3;
    localparam logic [2:0] PH_NEAR_PTR = 3'd4;
    localparam logic [2:0] PH_FAR_LO   = 3'd5;
    localparam logic [2:0] PH_FAR_HI   = 3'd6;

    logic [7:0]    r_byte;
    logic          r_start;
    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_hdr_lo, n_hdr_lo;
    logic          r_empty, n_empty;
    logic [7:0]    r_pend_low, n_pend_low;
    logic [7:0]    r_ptr_low, n_ptr_low;
    logic [15:0]   r_wp;
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_src;
    logic [7:0]    r_cnt;
    logic [15:0]   r_buf [WPR];
    logic [2:0]    r_buf_cnt;
    logic          r_ovalid;
    logic [15:0]   r_oword [4];
    logic [2:0]    r_ocount;
    logic          r_olast;
    logic          r_obad;

    logic [2:0]    phase_eff;
    logic          empty_eff;
    logic [15:0]   wp_eff;
    logic [AW-1:0] wptr_eff;
    logic [1:0]    act;
    logic [15:0]   lit_word;
    logic          is_copy;
    logic [15:0]   far_idx;
    logic [15:0]   copy_dist;
    logic          copy_bad;
    logic [16:0]   w17, d17, s17;
    logic [AW-1:0] src_start;
    logic          lit_go;
    logic          push;
    logic [15:0]   push_word;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_rdata;
    logic [15:0]   n_oword [4];

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + AW'(1);
        return q;
    endfunction

    // a start mark restarts parsing and the word count
    assign phase_eff = r_start ? PH_HDR_LO : r_phase;
    assign empty_eff = r_start ? 1'b0 : r_empty;
    assign wp_eff    = r_start ? '0 : r_wp;
    assign wptr_eff  = r_start ? '0 : r_wptr;

    // parse one byte
    always_comb begin
        n_phase    = r_phase;
        n_hdr_lo   = r_hdr_lo;
        n_empty    = empty_eff;
        n_pend_low = r_pend_low;
        n_ptr_low  = r_ptr_low;
        lit_word   = '0;
        is_copy    = 1'b0;
        act        = ACT_NONE;
        unique case (phase_eff)
            PH_HDR_LO: begin
                n_hdr_lo = r_byte;
                n_phase  = PH_HDR_HI;
            end
            PH_HDR_HI: begin
                n_empty = (r_hdr_lo == 8'd0) && (r_byte == 8'd0);
                n_phase = PH_W_LO;
            end
            PH_W_LO: begin
                if (!empty_eff) begin
                    n_pend_low = r_byte;
                    n_phase    = PH_W_HI;
                end
            end
            PH_W_HI: begin
                if (r_byte == i_near_tag) begin
                    n_phase = PH_NEAR_PTR;
                end else if (r_byte == i_far_tag) begin
                    n_phase = PH_FAR_LO;
                end else begin
                    lit_word = {r_byte, r_pend_low};
                    act      = ACT_LIT;
                    n_phase  = PH_W_LO;
                end
            end
            PH_NEAR_PTR: begin
                if (r_pend_low == 8'd0) begin
                    lit_word = {i_near_tag, r_byte};
                    act      = ACT_LIT;
                end else begin
                    is_copy = 1'b1;
                end
                n_phase = PH_W_LO;
            end
            PH_FAR_LO: begin
                if (r_pend_low == 8'd0) begin
                    lit_word = {i_far_tag, r_byte};
                    act      = ACT_LIT;
                    n_phase  = PH_W_LO;
                end else begin
                    n_ptr_low = r_byte;
                    n_phase   = PH_FAR_HI;
                end
            end
            PH_FAR_HI: begin
                is_copy = 1'b1;
                n_phase = PH_W_LO;
            end
            default: begin
                n_phase = PH_W_LO;
            end
        endcase
        if (is_copy) begin
            act = copy_bad ? ACT_BAD : ACT_COPY;
        end
    end

    // copy distance and validity
    assign far_idx = {r_byte, r_ptr_low};
    always_comb begin
        if (phase_eff == PH_NEAR_PTR) begin
            copy_dist = {8'd0, r_byte};
        end else if (far_idx < r_wp) begin
            copy_dist = r_wp - far_idx;
        end else begin
            copy_dist = '0;
        end
    end
    assign copy_bad = (copy_dist == 16'd0) || (copy_dist > r_wp)
                   || ({1'b0, copy_dist} > DEPTH17)
                   || (({1'b0, r_wp} + {9'd0, r_pend_low}) > {1'b0, WP_MAX});

    // source slot in the history ring
    assign w17 = 17'(r_wptr);
    assign d17 = {1'b0, copy_dist};
    assign s17 = (w17 >= d17) ? (w17 - d17) : (w17 + DEPTH17 - d17);
    assign src_start = s17[AW-1:0];

    // word push and history write
    assign lit_go    = i_cmd.decode && (act == ACT_LIT);
    assign push      = lit_go || i_cmd.wr;
    assign push_word = i_cmd.wr ? ram_rdata : lit_word;
    assign ram_we    = (lit_go && (wp_eff != WP_MAX)) || i_cmd.wr;
    assign ram_waddr = i_cmd.wr ? r_wptr : wptr_eff;

    nfwlz_ram #(
        .WIDTH (16),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (push_word),
        .i_re    (i_cmd.rd),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // parser and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR_LO;
            r_hdr_lo   <= '0;
            r_empty    <= 1'b0;
            r_pend_low <= '0;
            r_ptr_low  <= '0;
            r_wp       <= '0;
            r_wptr     <= '0;
            r_cnt      <= '0;
            r_start    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_start <= i_stream_start;
            end
            if (i_cmd.decode) begin
                r_start    <= 1'b0;
                r_phase    <= n_phase;
                r_hdr_lo   <= n_hdr_lo;
                r_empty    <= n_empty;
                r_pend_low <= n_pend_low;
                r_ptr_low  <= n_ptr_low;
                if (lit_go && (wp_eff != WP_MAX)) begin
                    r_wp   <= wp_eff + 16'd1;
                    r_wptr <= ring_inc(wptr_eff);
                end else begin
                    r_wp   <= wp_eff;
                    r_wptr <= wptr_eff;
                end
                r_cnt <= (act == ACT_COPY) ? r_pend_low : 8'd0;
            end
            if (i_cmd.wr) begin
                r_wp   <= r_wp + 16'd1;
                r_wptr <= ring_inc(r_wptr);
                r_cnt  <= r_cnt - 8'd1;
            end
        end
    end

    // byte capture and copy source
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.decode) begin
            r_src <= src_start;
        end else if (i_cmd.wr) begin
            r_src <= ring_inc(r_src);
        end
    end

    // packing buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_buf_cnt <= '0;
        end else if (push) begin
            r_buf_cnt <= r_buf_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < WPR; j++) begin
            if (push && (r_buf_cnt == 3'(j))) begin
                r_buf[j] <= push_word;
            end
        end
    end

    // result words, unused slots zero
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_oword[j] = '0;
        end
        for (int j = 0; j < WPR; j++) begin
            if (3'(j) < r_buf_cnt) begin
                n_oword[j] = r_buf[j];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int j = 0; j < 4; j++) begin
                r_oword[j] <= n_oword[j];
            end
            r_ocount <= r_buf_cnt;
            r_olast  <= (r_cnt == 8'd0);
            r_obad   <= 1'b0;
        end else if (i_cmd.emit_err) begin
            for (int j = 0; j < 4; j++) begin
                r_oword[j] <= '0;
            end
            r_ocount <= '0;
            r_olast  <= 1'b1;
            r_obad   <= 1'b1;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.word_a      = r_oword[0];
    assign o_out.word_b      = r_oword[1];
    assign o_out.word_c      = r_oword[2];
    assign o_out.word_d      = r_oword[3];
    assign o_out.word_count  = r_ocount;
    assign o_out.last_of_run = r_olast;
    assign o_out.bad_pointer = r_obad;

    // status
    assign o_sts.act       = act;
    assign o_sts.fill      = (r_buf_cnt == 3'(WPR - 1));
    assign o_sts.last_word = (r_cnt == 8'd1);
    assign o_sts.cnt_zero  = (r_cnt == 8'd0);
    assign o_sts.out_free  = !r_ovalid || o_out.ready;

    // checks
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_cnt <= 3'(WPR))
        else $error("packing buffer overfilled");
    a_wr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> r_cnt != 8'd0)
        else $error("history replay with no words left");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_err) |-> (!r_ovalid || o_out.ready))
        else $error("result register overwritten");
endmodule
`default_nettype wire

@@ rtl/nfwlz_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfwlz_ctrl
// sequencer: accept, decode, history replay and result hand-off
// ----------------------------------------------------------------------------
module nfwlz_ctrl
    import nfwlz_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_ready,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                unique case (i_sts.act)
                    ACT_LIT:  n_state = S_EMIT;
                    ACT_COPY: n_state = S_RD;
                    ACT_BAD:  n_state = S_ERR;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = (i_sts.fill || i_sts.last_word) ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.cnt_zero ? S_IDLE : S_RD;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> $past(r_state) == S_RD)
        else $error("replay write without a read");
    a_dec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DEC)
        else $error("accepted item not decoded");
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit && o_cmd.emit_err))
        else $error("two results loaded at once");
endmodule
`default_nettype wire

@@ rtl/near_far_word_lz_expander_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// near_far_word_lz_expander_unit
// expands a near/far tagged word stream into packed results of up to four words
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one compressed byte per item with a stream start mark; o_out
//   carries results of up to WORDS_PER_RESULT words, a last mark for the final
//   result caused by an item and a bad pointer flag for a rejected copy.
//   tags must be written over the apb port only while the block is idle;
//   the user is bound by this, the block itself does not enforce it.
// sequencing:
//   each byte is loaded in S_IDLE and parsed in S_DEC; a literal word goes
//   through S_EMIT to o_out, and a copy replays each word from the single
//   history ram with one read then one write per word.
// reset:
//   parser waits for a header low byte, word count is zero, tags go to their
//   defaults; the history ram is not cleared and needs no clearing pass.
// stall:
//   a result waits in the output register; the sequencer holds when the next
//   result is ready but the register is still full, and takes no new item.
// ----------------------------------------------------------------------------
module near_far_word_lz_expander_unit
    import nfwlz_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 4096,
    parameter int WORDS_PER_RESULT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    nfwlz_in_if.sink         i_in,
    nfwlz_out_if.source      o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    localparam logic REG_NEAR = 1'b0;
    localparam logic REG_FAR  = 1'b1;

    logic [7:0] r_near_tag;
    logic [7:0] r_far_tag;
    logic       cfg_wr;
    t_cmd       cmd;
    t_sts       sts;

    // tag registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_tag <= NEAR_TAG_RST;
            r_far_tag  <= FAR_TAG_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NEAR: r_near_tag <= pwdata[7:0];
                REG_FAR:  r_far_tag  <= pwdata[7:0];
                default:  r_near_tag <= r_near_tag;
            endcase
        end
    end

    assign prdata = {24'd0, (paddr[2] == REG_FAR) ? r_far_tag : r_near_tag};

    // sequencer
    nfwlz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    nfwlz_datapath #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .WORDS_PER_RESULT (WORDS_PER_RESULT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_data_byte    (i_in.data_byte),
        .i_stream_start (i_in.stream_start),
        .i_near_tag     (r_near_tag),
        .i_far_tag      (r_far_tag),
        .o_out          (o_out)
    );
endmodule
`default_nettype wire

@@ dv/nfwlz_expand_checker.sv @@
// ----------------------------------------------------------------------------
// nfwlz_expand_checker
// watches the byte and result channels, predicts the expanded words and
// compares every result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module nfwlz_expand_checker
    import nfwlz_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 4096,
    parameter int WORDS_PER_RESULT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_start,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_word_a,
    input  wire logic [15:0] i_word_b,
    input  wire logic [15:0] i_word_c,
    input  wire logic [15:0] i_word_d,
    input  wire logic [2:0]  i_word_count,
    input  wire logic        i_last_of_run,
    input  wire logic        i_bad_pointer,
    input  wire logic        i_tag_wr,
    input  wire logic [2:0]  i_tag_addr,
    input  wire logic [7:0]  i_tag_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_MAX = 65535;

    typedef enum logic [2:0] {
        PH_HDR_LO, PH_HDR_HI, PH_W_LO, PH_W_HI, PH_NEAR_PTR, PH_FAR_LO, PH_FAR_HI
    } t_phase;

    typedef struct packed {
        logic [15:0] wa;
        logic [15:0] wb;
        logic [15:0] wc;
        logic [15:0] wd;
        logic [2:0]  cnt;
        logic        last;
        logic        bad;
    } t_result;

    t_result expected_results[$];

    logic [7:0]  near_tag, far_tag;
    t_phase      phase;
    logic [7:0]  hdr_lo, cmd_count, ptr_lo;
    logic        empty_stream;
    int          words_made;
    logic [15:0] history[HISTORY_DEPTH];
    logic [15:0] run_words[$];
    bit          run_bad;

    // store one produced word, saturating the word count
    function automatic void put_word(logic [15:0] w);
        run_words.insert(run_words.size(), w);
        if (words_made < COUNT_MAX) begin
            history[words_made % HISTORY_DEPTH] = w;
            words_made++;
        end
    endfunction

    function automatic void replay(int copy_dist, int count);
        int src;
        if (copy_dist == 0 || copy_dist > words_made || copy_dist > HISTORY_DEPTH ||
            words_made + count > COUNT_MAX) begin
            run_bad = 1;
            return;
        end
        src = words_made - copy_dist;
        for (int i = 0; i < count; i++) put_word(history[(src + i) % HISTORY_DEPTH]);
    endfunction

    // advance the parser by one byte and queue the results it causes
    function automatic void expand_byte(logic [7:0] b, logic start);
        int idx, nres, n;
        t_result r;
        run_words.delete();
        run_bad = 0;
        if (start) begin
            phase = PH_HDR_LO;
            empty_stream = 1'b0;
            words_made = 0;
        end
        case (phase)
            PH_HDR_LO: begin
                hdr_lo = b;
                phase = PH_HDR_HI;
            end
            PH_HDR_HI: begin
                empty_stream = (hdr_lo == 0 && b == 0);
                phase = PH_W_LO;
            end
            PH_W_LO: begin
                if (!empty_stream) begin
                    cmd_count = b;
                    phase = PH_W_HI;
                end
            end
            PH_W_HI: begin
                if (b == near_tag) phase = PH_NEAR_PTR;
                else if (b == far_tag) phase = PH_FAR_LO;
                else begin
                    put_word({b, cmd_count});
                    phase = PH_W_LO;
                end
            end
            PH_NEAR_PTR: begin
                if (cmd_count == 0) put_word({near_tag, b});
                else replay(b, cmd_count);
                phase = PH_W_LO;
            end
            PH_FAR_LO: begin
                if (cmd_count == 0) begin
                    put_word({far_tag, b});
                    phase = PH_W_LO;
                end else begin
                    ptr_lo = b;
                    phase = PH_FAR_HI;
                end
            end
            default: begin
                idx = {b, ptr_lo};
                replay((idx < words_made) ? words_made - idx : 0, cmd_count);
                phase = PH_W_LO;
            end
        endcase
        if (run_bad) begin
            r = '0;
            r.last = 1'b1;
            r.bad = 1'b1;
            expected_results.insert(expected_results.size(), r);
            return;
        end
        nres = (run_words.size() + WORDS_PER_RESULT - 1) / WORDS_PER_RESULT;
        for (int k = 0; k < nres; k++) begin
            n = run_words.size() - k * WORDS_PER_RESULT;
            if (n > WORDS_PER_RESULT) n = WORDS_PER_RESULT;
            r = '0;
            r.wa = run_words[k * WORDS_PER_RESULT];
            if (n > 1) r.wb = run_words[k * WORDS_PER_RESULT + 1];
            if (n > 2) r.wc = run_words[k * WORDS_PER_RESULT + 2];
            if (n > 3) r.wd = run_words[k * WORDS_PER_RESULT + 3];
            r.cnt = 3'(n);
            r.last = (k + 1 == nres);
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    // compare one field and count a miss
    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            near_tag <= NEAR_TAG_RST;
            far_tag <= FAR_TAG_RST;
            phase = PH_HDR_LO;
            hdr_lo = '0;
            cmd_count = '0;
            ptr_lo = '0;
            empty_stream = 1'b0;
            words_made = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            // results leave before this edge's byte can have caused any
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no prediction waiting");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("word_a", e.wa, i_word_a);
                    check_field("word_b", e.wb, i_word_b);
                    check_field("word_c", e.wc, i_word_c);
                    check_field("word_d", e.wd, i_word_d);
                    check_field("word_count", e.cnt, i_word_count);
                    check_field("last_of_run", e.last, i_last_of_run);
                    check_field("bad_pointer", e.bad, i_bad_pointer);
                end
            end
            if (i_in_valid && i_in_ready) expand_byte(i_in_byte, i_in_start);
            // tag register writes
            if (i_tag_wr) begin
                if (i_tag_addr == 3'd0) near_tag <= i_tag_data;
                else if (i_tag_addr == 3'd4) far_tag <= i_tag_data;
            end
        end
    end
endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives compressed streams with near and far copies, literal tags, bad
// pointers and empty streams under random gaps, stalls and tag settings
// ----------------------------------------------------------------------------
module tb;
    import nfwlz_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam logic [2:0] ADDR_NEAR_TAG = 3'd0;
    localparam logic [2:0] ADDR_FAR_TAG  = 3'd4;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          fail_count, pending, idle_cycles;
    bit          long_hold, hold_done, stim_done;
    logic [7:0]  cur_near, cur_far;
    int          words_sent;

    nfwlz_in_if  byte_ch();
    nfwlz_out_if result_ch();

    near_far_word_lz_expander_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(byte_ch.sink), .o_out(result_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    nfwlz_expand_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(byte_ch.valid), .i_in_ready(byte_ch.ready),
        .i_in_byte(byte_ch.data_byte), .i_in_start(byte_ch.stream_start),
        .i_out_valid(result_ch.valid), .i_out_ready(result_ch.ready),
        .i_word_a(result_ch.word_a), .i_word_b(result_ch.word_b),
        .i_word_c(result_ch.word_c), .i_word_d(result_ch.word_d),
        .i_word_count(result_ch.word_count), .i_last_of_run(result_ch.last_of_run),
        .i_bad_pointer(result_ch.bad_pointer),
        .i_tag_wr(psel && penable && pwrite && pready), .i_tag_addr(paddr),
        .i_tag_data(pwdata[7:0]), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, sometimes long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // send one byte and wait for its acceptance
    task automatic send_byte(logic [7:0] b, logic start = 0);
        repeat (gap_len() * ($urandom_range(0, 3) == 0)) @(negedge i_clk);
        byte_ch.valid = 1;
        byte_ch.data_byte = b;
        byte_ch.stream_start = start;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        byte_ch.valid = 0;
        byte_ch.stream_start = 0;
    endtask

    task automatic send_word(logic [15:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    task automatic write_tag(logic [2:0] addr, logic [7:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_NEAR_TAG) cur_near = val;
        else cur_far = val;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES / 4) @(negedge i_clk);
    endtask

    task automatic start_stream(logic [15:0] len);
        send_byte(len[7:0], 1);
        send_byte(len[15:8]);
        words_sent = 0;
    endtask

    // a plain literal whose high byte misses both tags
    task automatic send_literal();
        logic [15:0] w;
        w = 16'($urandom);
        while (w[15:8] == cur_near || w[15:8] == cur_far) w[15:8] = w[15:8] + 1;
        send_word(w);
        words_sent++;
    endtask

    // random well-formed stream with mostly valid copies
    task automatic random_stream(int n_cmds);
        int d, cnt;
        start_stream(16'($urandom_range(1, 65535)));
        for (int i = 0; i < n_cmds; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_literal();
                4, 5: begin
                    if (words_sent == 0) send_literal();
                    else begin
                        cnt = $urandom_range(1, 12);
                        d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, words_sent);
                        if (d > 255) d = 255;
                        send_byte(8'(cnt));
                        send_byte(cur_near);
                        send_byte(8'(d));
                        if (d != 0 && d <= words_sent) words_sent += cnt;
                    end
                end
                6, 7: begin
                    if (words_sent == 0) send_literal();
                    else begin
                        cnt = $urandom_range(1, 12);
                        d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, words_sent - 1);
                        send_byte(8'(cnt));
                        send_byte(cur_far);
                        send_byte(d[7:0]);
                        send_byte(d[15:8]);
                        if (d < words_sent) words_sent += cnt;
                    end
                end
                8: begin
                    send_byte(8'd0);
                    send_byte(($urandom_range(0, 1) != 0) ? cur_near : cur_far);
                    send_byte(8'($urandom));
                    words_sent++;
                end
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // result side: random stalls plus one long hold
    initial begin
        result_ch.ready = 0;
        hold_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                result_ch.ready <= 0;
                repeat (300) @(negedge i_clk);
                hold_done = 1;
            end
            if (!stim_done && $urandom_range(0, 40) == 0) begin
                result_ch.ready <= 0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                result_ch.ready <= ($urandom_range(0, 3) != 0) || stim_done;
            end
        end
    end

    // watchdog on accepted items
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
                || psel || !i_rst_n)
                idle_cycles = 0;
            else if (byte_ch.valid || pending != 0)
                idle_cycles++;
            else
                idle_cycles = 0;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        byte_ch.valid = 0; byte_ch.data_byte = 0; byte_ch.stream_start = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        long_hold = 0; stim_done = 0;
        cur_near = NEAR_TAG_RST; cur_far = FAR_TAG_RST;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // no start mark after reset, then directed cases
        send_byte(8'h05); send_byte(8'h00);
        send_word(16'h0000); send_word(16'hFFFF); words_sent = 2;
        send_byte(8'd1); send_byte(cur_near); send_byte(8'd0);       // near distance zero
        send_byte(8'd4); send_byte(cur_near); send_byte(8'd3);       // distance too far
        send_byte(8'd255); send_byte(cur_near); send_byte(8'd1);     // long overlapping copy
        send_byte(8'd0); send_byte(cur_near); send_byte(8'hFF);      // near literal
        send_byte(8'd0); send_byte(cur_far); send_byte(8'h00);       // far literal
        send_byte(8'd6); send_byte(cur_far); send_byte(8'h01); send_byte(8'h00);
        send_byte(8'd2); send_byte(cur_far); send_byte(8'hFF); send_byte(8'hFF);
        // empty stream ignores everything after
        send_byte(8'h00, 1); send_byte(8'h00);
        send_byte(8'h34); send_byte(8'h12); send_byte(8'hA7);
        wait_idle();

        // random streams across tag settings, extremes included
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin write_tag(ADDR_NEAR_TAG, 8'h00); write_tag(ADDR_FAR_TAG, 8'hFF); end
                1: begin write_tag(ADDR_NEAR_TAG, 8'hFF); write_tag(ADDR_FAR_TAG, 8'h00); end
                2: begin write_tag(ADDR_NEAR_TAG, 8'h55); write_tag(ADDR_FAR_TAG, 8'h55); end
                3: begin write_tag(ADDR_NEAR_TAG, 8'($urandom)); write_tag(ADDR_FAR_TAG, 8'($urandom)); end
                default: begin write_tag(ADDR_NEAR_TAG, NEAR_TAG_RST); write_tag(ADDR_FAR_TAG, FAR_TAG_RST); end
            endcase
            if (p == 2) long_hold = 1;
            for (int s = 0; s < 2; s++) random_stream($urandom_range(4, 9));
            if (p == 3) start_stream(16'd0);
            wait_idle();
        end

        stim_done = 1;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/nfwlz_pkg.sv
rtl/nfwlz_in_if.sv
rtl/nfwlz_out_if.sv
rtl/nfwlz_ram.sv
rtl/nfwlz_datapath.sv
rtl/nfwlz_ctrl.sv
rtl/near_far_word_lz_expander_unit.sv
dv/nfwlz_expand_checker.sv
dv/tb.sv
